### src/phs_pkg.sv
// Shared types and constants for the priority heap scheduler.
// No dependencies; phs_timing and the top level use it.
`timescale 1ns / 1ps

package phs_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned PrioBitsDef   = 8;
  localparam int unsigned OccW          = 5;

  typedef enum logic {
    FUNC_ENQ  = 1'b0,
    FUNC_DISP = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DISP  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] proc_id;
    logic [15:0] arrival;
    logic [7:0]  priority_req;
    logic [15:0] burst;
  } in_t;

  typedef struct packed {
    status_e         status;
    logic [15:0]     out_id;
    logic [15:0]     out_arrival;
    logic [15:0]     out_burst;
    logic [31:0]     completion;
    logic [31:0]     turnaround;
    logic [31:0]     waiting;
    logic [31:0]     response;
    logic [OccW-1:0] occupancy;
  } out_t;

  // Heap record without its key; the key width is set by a parameter.
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] arrival;
    logic [15:0] burst;
  } rec_base_t;

  // Status of the timing unit as seen by the controller.
  typedef struct packed {
    logic        busy;
    logic [31:0] completion;
    logic [31:0] turnaround;
    logic [31:0] waiting;
  } tm_res_t;

endpackage

### src/phs_heap_mem.sv
// Heap record store: one write port, two registered read ports.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module phs_heap_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 56
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] ra_addr_i,
  input  logic [$clog2(DEPTH)-1:0] rb_addr_i,
  output logic [WIDTH-1:0]         ra_data_o,
  output logic [WIDTH-1:0]         rb_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] ra_q, rb_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q <= mem_q[ra_addr_i];
    rb_q <= mem_q[rb_addr_i];
  end

  assign ra_data_o = ra_q;
  assign rb_data_o = rb_q;

endmodule

### src/phs_timing.sv
// System time, then turnaround, then waiting time for each dispatch.
// Depends on phs_pkg.
`timescale 1ns / 1ps

module phs_timing (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [15:0]      arrival_i,
  input  logic [15:0]      burst_i,
  output phs_pkg::tm_res_t res_o
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_TAT  = 3'b010,
    T_WAIT = 3'b100
  } tstate_e;

  tstate_e     state_q, state_d;
  logic [31:0] sys_q, sys_d;
  logic [15:0] arr_q, burst_q;
  logic [31:0] tat_q, wt_q;
  logic [31:0] base;
  logic [32:0] sum;

  // Start: move time up to arrival, add burst, saturate.
  always_comb begin
    base = (sys_q < 32'(arrival_i)) ? 32'(arrival_i) : sys_q;
    sum  = 33'(base) + 33'(burst_i);
    sys_d = sys_q;
    if (state_q == T_IDLE && start_i) begin
      sys_d = sum[32] ? '1 : sum[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE:  if (start_i) state_d = T_TAT;
      T_TAT:   state_d = T_WAIT;
      T_WAIT:  state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      sys_q   <= '0;
    end else begin
      state_q <= state_d;
      sys_q   <= sys_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == T_IDLE && start_i) begin
      arr_q   <= arrival_i;
      burst_q <= burst_i;
    end
    if (state_q == T_TAT) begin
      tat_q <= (sys_q >= 32'(arr_q)) ? sys_q - 32'(arr_q) : '0;
    end
    if (state_q == T_WAIT) begin
      wt_q <= (tat_q >= 32'(burst_q)) ? tat_q - 32'(burst_q) : '0;
    end
  end

  assign res_o.busy       = (state_q != T_IDLE);
  assign res_o.completion = sys_q;
  assign res_o.turnaround = tat_q;
  assign res_o.waiting    = wt_q;

endmodule

### src/priority_heap_scheduler_top.sv
// Priority heap scheduler: controller, heap sifting and output register.
// Depends on phs_pkg, phs_heap_mem and phs_timing.
`timescale 1ns / 1ps

// Channel  Handshake                   Payload                Direction
// in       in_valid_i / in_ready_o     in_data_i  (in_t)      enqueue or dispatch
// out      out_valid_o / out_ready_i   out_data_o (out_t)     one result per transaction
//
// Steps: an enqueue sifts up until the record reaches the root or its parent is not
// lower; a dispatch loads root and last entry, then sifts down; full or empty go
// straight to output. Each heap level is a memory read, then a compare and write back.
// Reset: state, count, system time and output valid clear at once; the record
// store is not cleared, the count bounds every read.
// Stalls: a transaction is taken while the last result waits; its result waits for out_ready_i.

module priority_heap_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = phs_pkg::QueueDepthDef,
  parameter int unsigned PRIO_BITS   = phs_pkg::PrioBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  phs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output phs_pkg::out_t out_data_o
);

  localparam int IdxW  = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int ChW   = IdxW + 2;
  localparam int BaseW = $bits(phs_pkg::rec_base_t);
  localparam int WordW = BaseW + PRIO_BITS;
  localparam int OccW  = phs_pkg::OccW;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b000_0001,
    S_UP_RD   = 7'b000_0010,
    S_UP_CMP  = 7'b000_0100,
    S_DQ_LOAD = 7'b000_1000,
    S_DN_RD   = 7'b001_0000,
    S_DN_CMP  = 7'b010_0000,
    S_OUT     = 7'b100_0000
  } state_e;

  state_e                state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  logic [IdxW-1:0]       pos_q, pos_d;
  phs_pkg::rec_base_t    rec_q, rec_d;
  logic [PRIO_BITS-1:0]  prio_q, prio_d;
  phs_pkg::out_t         res_q, res_d;
  phs_pkg::out_t         out_q, out_d;

  // Memory port signals.
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr, ra_addr, rb_addr;
  logic [WordW-1:0]      mem_wdata, ra_data, rb_data;

  // Decoded read data.
  logic [PRIO_BITS-1:0]  ra_prio, rb_prio, best_prio;
  phs_pkg::rec_base_t    ra_base, rb_base;

  // Heap addressing.
  logic [ChW-1:0]        l_w, r_w, cnt_w;
  logic                  l_ok, r_ok, take_l, take_r;
  logic [IdxW-1:0]       pos_m1, parent;
  logic [CntW-1:0]       last;
  logic                  full, empty;

  phs_pkg::tm_res_t      tm_res;
  logic                  tm_start;

  logic [PRIO_BITS-1:0]  in_prio;
  phs_pkg::rec_base_t    in_rec;
  logic [WordW-1:0]      rec_word;

  assign in_prio        = PRIO_BITS'(in_data_i.priority_req);
  assign in_rec.id      = in_data_i.proc_id;
  assign in_rec.arrival = in_data_i.arrival;
  assign in_rec.burst   = in_data_i.burst;
  assign rec_word       = {prio_q, rec_q};

  assign ra_prio = ra_data[WordW-1 -: PRIO_BITS];
  assign rb_prio = rb_data[WordW-1 -: PRIO_BITS];
  assign ra_base = phs_pkg::rec_base_t'(ra_data[BaseW-1:0]);
  assign rb_base = phs_pkg::rec_base_t'(rb_data[BaseW-1:0]);

  assign l_w    = ChW'({pos_q, 1'b1});
  assign r_w    = l_w + ChW'(1);
  assign cnt_w  = ChW'(count_q);
  assign l_ok   = (l_w < cnt_w);
  assign r_ok   = (r_w < cnt_w);
  assign pos_m1 = pos_q - IdxW'(1);
  assign parent = pos_m1 >> 1;
  assign last   = count_q - CntW'(1);
  assign full   = (count_q == CntW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);

  // Sift-down choice: left on strictly greater, right on strictly greater
  // than the best so far.
  assign take_l    = l_ok && (ra_prio > prio_q);
  assign best_prio = take_l ? ra_prio : prio_q;
  assign take_r    = r_ok && (rb_prio > best_prio);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    rec_d       = rec_q;
    prio_d      = prio_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = rec_word;
    ra_addr     = '0;
    rb_addr     = '0;
    tm_start    = 1'b0;

    case (state_q)
      S_IDLE: begin
        // Root and last entry, used when a dispatch arrives.
        rb_addr = empty ? '0 : last[IdxW-1:0];
        if (in_valid_i) begin
          res_d = '0;
          if (in_data_i.func == phs_pkg::FUNC_ENQ) begin
            if (full) begin
              res_d.status = phs_pkg::ST_FULL;
              state_d      = S_OUT;
            end else begin
              res_d.status = phs_pkg::ST_ENQ;
              rec_d        = in_rec;
              prio_d       = in_prio;
              pos_d        = count_q[IdxW-1:0];
              count_d      = count_q + CntW'(1);
              state_d      = S_UP_RD;
            end
          end else begin
            if (empty) begin
              res_d.status = phs_pkg::ST_EMPTY;
              state_d      = S_OUT;
            end else begin
              count_d = last;
              state_d = S_DQ_LOAD;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_q == '0) begin
          mem_we  = 1'b1;
          state_d = S_OUT;
        end else begin
          ra_addr = parent;
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mem_we = 1'b1;
        if (ra_prio < prio_q) begin
          // Parent moves down into the hole.
          mem_wdata = ra_data;
          pos_d     = parent;
          state_d   = S_UP_RD;
        end else begin
          state_d = S_OUT;
        end
      end

      S_DQ_LOAD: begin
        res_d.status      = phs_pkg::ST_DISP;
        res_d.out_id      = ra_base.id;
        res_d.out_arrival = ra_base.arrival;
        res_d.out_burst   = ra_base.burst;
        tm_start          = 1'b1;
        rec_d             = rb_base;
        prio_d            = rb_prio;
        pos_d             = '0;
        state_d           = empty ? S_OUT : S_DN_RD;
      end

      S_DN_RD: begin
        ra_addr = l_ok ? l_w[IdxW-1:0] : '0;
        rb_addr = r_ok ? r_w[IdxW-1:0] : '0;
        state_d = S_DN_CMP;
      end

      S_DN_CMP: begin
        mem_we = 1'b1;
        if (take_r) begin
          mem_wdata = rb_data;
          pos_d     = r_w[IdxW-1:0];
          state_d   = S_DN_RD;
        end else if (take_l) begin
          mem_wdata = ra_data;
          pos_d     = l_w[IdxW-1:0];
          state_d   = S_DN_RD;
        end else begin
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (!tm_res.busy && (!out_valid_q || out_ready_i)) begin
          out_d           = res_q;
          out_d.occupancy = OccW'(count_q);
          if (res_q.status == phs_pkg::ST_DISP) begin
            out_d.completion = tm_res.completion;
            out_d.turnaround = tm_res.turnaround;
            out_d.waiting    = tm_res.waiting;
            out_d.response   = tm_res.waiting;
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    rec_q  <= rec_d;
    prio_q <= prio_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  phs_heap_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (WordW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .ra_addr_i (ra_addr),
    .rb_addr_i (rb_addr),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data)
  );

  phs_timing u_timing (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (tm_start),
    .arrival_i (ra_base.arrival),
    .burst_i   (ra_base.burst),
    .res_o     (tm_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Occupancy never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("heap count above depth");

  // A result only appears after passing through the output state.
  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q) == S_OUT)
    else $error("result loaded outside output state");

  // Dispatched completion time always covers the burst.
  a_completion_covers_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == phs_pkg::ST_DISP) |->
      out_q.completion >= 32'(out_q.out_burst))
    else $error("completion below burst");

  // An accepted enqueue on a non-full queue grows the count by one.
  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.func == phs_pkg::FUNC_ENQ && !full) |=>
      count_q == $past(count_q) + CntW'(1))
    else $error("enqueue count update lost");

endmodule

### test/testbench.sv
// Self-checking testbench for priority_heap_scheduler_top: random and directed
// enqueue and dispatch traffic, scored against an in-bench heap scheduler model.
// Depends on phs_pkg and the scheduler RTL in src.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned QDEPTH      = phs_pkg::QueueDepthDef;
  localparam int unsigned HOLD_CYCLES = 300;   // long output stall
  localparam int unsigned QUIET_LIMIT = 4000;  // cycles without any transaction
  localparam int unsigned DRAIN_WAIT  = 40;    // tail after the last result

  // One ready-queue entry as the scheduler keeps it.
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] arrival;
    logic [7:0]  prio;
    logic [15:0] burst;
  } sched_rec_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  phs_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  phs_pkg::out_t out_data_o;

  priority_heap_scheduler_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Scheduler model state: heap of records, fill level and system clock.
  sched_rec_t  rq_heap [QDEPTH];
  int unsigned rq_count;
  logic [31:0] sys_clock;

  phs_pkg::out_t sched_results_due [$];  // predicted results, oldest first
  int            error_count;

  // Idle rates in percent; the main initial block changes them per phase.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          stall_request;  // asks the receiver for one long hold-off
  int unsigned hold_left;
  int unsigned quiet_cycles;

  // Applies one transaction to the model and returns the result it must yield.
  function automatic phs_pkg::out_t predict_schedule(phs_pkg::in_t req);
    phs_pkg::out_t res;
    sched_rec_t    rec;
    sched_rec_t    tmp;
    int unsigned   pos;
    int unsigned   parent;
    int unsigned   left;
    int unsigned   right;
    int unsigned   best;
    logic [32:0]   sum;
    logic [31:0]   tat;
    logic [31:0]   wt;
    res = '0;
    if (req.func == phs_pkg::FUNC_ENQ) begin
      if (rq_count >= QDEPTH) begin
        res.status = phs_pkg::ST_FULL;
      end else begin
        rec.id      = req.proc_id;
        rec.arrival = req.arrival;
        rec.prio    = req.priority_req;  // key is the full byte at PRIO_BITS = 8
        rec.burst   = req.burst;
        rq_heap[rq_count] = rec;
        pos = rq_count;
        // climb while the parent is strictly lower; ties keep the older entry on top
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (rq_heap[parent].prio < rq_heap[pos].prio) begin
            tmp = rq_heap[parent];
            rq_heap[parent] = rq_heap[pos];
            rq_heap[pos] = tmp;
            pos = parent;
          end else begin
            break;
          end
        end
        rq_count++;
        res.status = phs_pkg::ST_ENQ;
      end
    end else if (rq_count == 0) begin
      res.status = phs_pkg::ST_EMPTY;
    end else begin
      rec = rq_heap[0];
      rq_heap[0] = rq_heap[rq_count - 1];
      rq_count--;
      pos = 0;
      // left wins on strictly greater, right only if strictly above the best so far
      while (pos < rq_count) begin
        left  = 2 * pos + 1;
        right = 2 * pos + 2;
        best  = pos;
        if (left < rq_count && rq_heap[left].prio > rq_heap[best].prio) best = left;
        if (right < rq_count && rq_heap[right].prio > rq_heap[best].prio) best = right;
        if (best == pos) break;
        tmp = rq_heap[best];
        rq_heap[best] = rq_heap[pos];
        rq_heap[pos] = tmp;
        pos = best;
      end
      if (sys_clock < {16'd0, rec.arrival}) sys_clock = {16'd0, rec.arrival};
      sum = {1'b0, sys_clock} + {17'd0, rec.burst};
      sys_clock = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      tat = (sys_clock >= {16'd0, rec.arrival}) ? sys_clock - {16'd0, rec.arrival} : '0;
      wt  = (tat >= {16'd0, rec.burst}) ? tat - {16'd0, rec.burst} : '0;
      res.status      = phs_pkg::ST_DISP;
      res.out_id      = rec.id;
      res.out_arrival = rec.arrival;
      res.out_burst   = rec.burst;
      res.completion  = sys_clock;
      res.turnaround  = tat;
      res.waiting     = wt;
      res.response    = wt;
    end
    res.occupancy = phs_pkg::OccW'(rq_count);
    return res;
  endfunction

  function automatic phs_pkg::in_t make_req(phs_pkg::func_e f, logic [15:0] id,
                                            logic [15:0] arr, logic [7:0] prio,
                                            logic [15:0] burst);
    phs_pkg::in_t req;
    req.func         = f;
    req.proc_id      = id;
    req.arrival      = arr;
    req.priority_req = prio;
    req.burst        = burst;
    return req;
  endfunction

  // Random request. Narrow priorities give many ties, small arrival and
  // burst values keep the system clock near the arrivals so both the
  // idle-advance and the back-to-back cases of the time update occur.
  function automatic phs_pkg::in_t random_req(int unsigned enq_pct);
    phs_pkg::in_t req;
    req.func         = ($urandom_range(99) < enq_pct) ? phs_pkg::FUNC_ENQ
                                                      : phs_pkg::FUNC_DISP;
    req.proc_id      = 16'($urandom);
    req.arrival      = ($urandom_range(1) == 0) ? 16'($urandom_range(300)) : 16'($urandom);
    req.priority_req = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
    req.burst        = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(50));
    return req;
  endfunction

  // Offers one transaction, idling with the sender's rate in each cycle first,
  // and records the prediction once it is accepted. Entered and left at a
  // falling edge; valid stays high on return so back-to-back offers need no toggle.
  task automatic send_item(input phs_pkg::in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sched_results_due.push_back(predict_schedule(req));
    @(negedge clk_i);
  endtask

  // Empty dispatch, then records at the field extremes, including a tie, then two dispatches.
  task automatic test_edge_cases();
    send_item(make_req(phs_pkg::FUNC_DISP, 16'h1234, 16'h5678, 8'h9A, 16'hBCDE));
    send_item(make_req(phs_pkg::FUNC_ENQ, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_item(make_req(phs_pkg::FUNC_ENQ, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_item(make_req(phs_pkg::FUNC_ENQ, 16'hA5A5, 16'h0001, 8'hFF, 16'h5A5A));
    send_item(make_req(phs_pkg::FUNC_ENQ, 16'h5A5A, 16'hFFFE, 8'h00, 16'h0001));
    send_item(make_req(phs_pkg::FUNC_DISP, '0, '0, '0, '0));
    send_item(make_req(phs_pkg::FUNC_DISP, '0, '0, '0, '0));
  endtask

  // Top the queue up to its depth, overflow it once, then dispatch one.
  task automatic test_queue_full();
    int unsigned room;
    room = QDEPTH - rq_count;
    repeat (room) send_item(random_req(100));
    send_item(make_req(phs_pkg::FUNC_ENQ, 16'hDEAD, 16'hBEEF, 8'h80, 16'h0100));
    send_item(make_req(phs_pkg::FUNC_DISP, '0, '0, '0, '0));
  endtask

  // Receiver stops for a long stretch while the sender keeps offering:
  // the output register fills and the input must stall.
  task automatic test_output_backpressure();
    int unsigned save_send;
    save_send     = send_idle_pct;
    send_idle_pct = 0;
    stall_request = 1'b1;
    repeat (40) send_item(random_req(60));
    send_idle_pct = save_send;
  endtask

  // Mixed traffic in short runs, each with its own enqueue bias, so the
  // queue swings between empty and full.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned enq_pct;
    int unsigned k;
    enq_pct = 50;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(3))
          0: enq_pct = 20;
          1: enq_pct = 50;
          2: enq_pct = 75;
          default: enq_pct = 92;
        endcase
      end
      send_item(random_req(enq_pct));
    end
  endtask

  // Receiver: one long hold-off on request, otherwise random stalls.
  always @(negedge clk_i) begin
    if (stall_request) begin
      stall_request = 1'b0;
      hold_left     = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    phs_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sched_results_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, out_data_o);
      end else begin
        want = sched_results_due.pop_front();
        check_field("status", 32'(want.status), 32'(out_data_o.status));
        check_field("out_id", 32'(want.out_id), 32'(out_data_o.out_id));
        check_field("out_arrival", 32'(want.out_arrival), 32'(out_data_o.out_arrival));
        check_field("out_burst", 32'(want.out_burst), 32'(out_data_o.out_burst));
        check_field("completion", want.completion, out_data_o.completion);
        check_field("turnaround", want.turnaround, out_data_o.turnaround);
        check_field("waiting", want.waiting, out_data_o.waiting);
        check_field("response", want.response, out_data_o.response);
        check_field("occupancy", 32'(want.occupancy), 32'(out_data_o.occupancy));
      end
    end
  end

  // Watchdog: a long stretch with no transaction on either side is a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    rst_ni        = 1'b0;
    error_count   = 0;
    quiet_cycles  = 0;
    stall_request = 1'b0;
    hold_left     = 0;
    rq_count      = 0;
    sys_clock     = '0;
    send_idle_pct = 33;
    recv_idle_pct = 62;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // phase 1: sparse sender, hesitant receiver
    test_edge_cases();
    test_queue_full();
    test_output_backpressure();
    test_random_traffic(420);

    // phase 2: rates swapped
    send_idle_pct = 62;
    recv_idle_pct = 33;
    test_random_traffic(420);

    // phase 3: full throughput on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(420);

    in_valid_i <= 1'b0;
    while (sched_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
